// ===== design/lan_response_frame_decoder_core_defines.svh =====
// Assertion macros for the LAN response frame decoder RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef LAN_RESPONSE_FRAME_DECODER_CORE_DEFINES_SVH
`define LAN_RESPONSE_FRAME_DECODER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define LRFD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lrfd check failed");

// Next-cycle implication, checked out of reset.
`define LRFD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lrfd check failed");

`else

`define LRFD_ASSERT_NOW(label, clk, rstn, ante, cons)
`define LRFD_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== design/lrfd_pkg.sv =====
// Types and constants of the LAN response frame decoder.
// No dependencies; used by every module of the block.
package lrfd_pkg;

    // Captured window: datagram bytes 2 to 12.
    localparam int unsigned CAP_FIRST = 2;
    localparam int unsigned CAP_COUNT = 11;
    localparam int unsigned CAP_LAST  = CAP_FIRST + CAP_COUNT - 1;

    localparam logic [3:0] POS_MAX = 4'd15;

    // Header and X-header codes.
    localparam logic [7:0] HDR_LAN       = 8'h40;
    localparam logic [7:0] XH_STATUS     = 8'h61;
    localparam logic [7:0] XH_POWER      = 8'h62;
    localparam logic [7:0] XH_UNKNOWN_A  = 8'h63;
    localparam logic [7:0] XH_CV         = 8'h64;
    localparam logic [7:0] XH_UNKNOWN_B  = 8'hF3;
    localparam logic [7:0] XH_LOCO       = 8'hEF;

    // Status codes.
    localparam logic [7:0] ST_OFF        = 8'h00;
    localparam logic [7:0] ST_ON         = 8'h01;
    localparam logic [7:0] ST_PROG       = 8'h02;
    localparam logic [7:0] ST_CV_NACK    = 8'h13;

    // Track power codes.
    localparam logic [7:0] PWR_ON        = 8'h00;
    localparam logic [7:0] PWR_PROG      = 8'h20;

    // Loco step mode codes in the frame.
    localparam logic [2:0] STEP_CODE_14  = 3'd0;
    localparam logic [2:0] STEP_CODE_28  = 3'd2;
    localparam logic [2:0] STEP_CODE_128 = 3'd4;

    typedef enum logic [2:0] {
        KIND_NONE      = 3'd0,
        KIND_UNKNOWN   = 3'd1,
        KIND_POWER_OFF = 3'd2,
        KIND_POWER_ON  = 3'd3,
        KIND_PROG      = 3'd4,
        KIND_CV_NACK   = 3'd5,
        KIND_CV_RESULT = 3'd6,
        KIND_LOCO_INFO = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        MODE_14      = 2'd0,
        MODE_28      = 2'd1,
        MODE_128     = 2'd2,
        MODE_UNKNOWN = 2'd3
    } mode_t;

    typedef logic [CAP_COUNT-1:0][7:0] frame_t;

    // Kept loco and CV records, reported with every result.
    typedef struct packed {
        logic [7:0]  cv_value;
        logic [15:0] cv_number;
        logic [27:0] function_bits;
        logic        light_on;
        logic        forward;
        logic        occupied;
        logic [6:0]  loco_speed;
        mode_t       speed_mode;
        logic [15:0] loco_address;
    } kept_t;

endpackage

// ===== design/lrfd_capture.sv =====
// Byte capture for the LAN response frame decoder: byte counter, capture
// window and the registered frame handed to the decoder. Depends on lrfd_pkg.
module lrfd_capture import lrfd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       advance_ok,
    output logic       frame_valid,
    output frame_t     frame
);

    logic [3:0] pos_reg, pos_next;
    frame_t     cap_reg, cap_next;
    frame_t     frame_reg, frame_next;
    logic       frame_valid_reg, frame_valid_next;
    logic       accept;
    frame_t     cap_with_byte;
    logic [3:0] slot;

    // A finished frame waits here until the result register can take it.
    assign s_tready = !frame_valid_reg || advance_ok;
    assign accept   = s_tvalid && s_tready;
    assign slot     = pos_reg - 4'(CAP_FIRST);

    // Capture window with the current byte placed at its position.
    always_comb begin
        cap_with_byte = cap_reg;
        if (pos_reg >= 4'(CAP_FIRST) && pos_reg <= 4'(CAP_LAST)) begin
            cap_with_byte[slot] = s_tdata;
        end
    end

    // Counter, window and frame register updates.
    always_comb begin
        pos_next         = pos_reg;
        cap_next         = cap_reg;
        frame_next       = frame_reg;
        frame_valid_next = frame_valid_reg && !advance_ok;
        if (accept) begin
            if (s_tlast) begin
                frame_next       = cap_with_byte;
                frame_valid_next = 1'b1;
                cap_next         = '0;
                pos_next         = '0;
            end else begin
                cap_next = cap_with_byte;
                if (pos_reg != POS_MAX) begin
                    pos_next = pos_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            cap_reg         <= '0;
            frame_valid_reg <= 1'b0;
        end else begin
            pos_reg         <= pos_next;
            cap_reg         <= cap_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

endmodule

// ===== design/lrfd_decode.sv =====
// Frame classification and record decoding for the LAN response frame decoder.
// Pure combinational logic; depends on lrfd_pkg.
module lrfd_decode import lrfd_pkg::*; (
    input  frame_t frame,
    input  kept_t  kept_cur,
    output kind_t  kind,
    output kept_t  kept_new
);

    logic [7:0]  b2, b4, b5, b6, b7, b8, b9, b10, b11, b12;
    logic [15:0] addr;
    logic [6:0]  s14;
    logic [4:0]  c28;

    assign b2  = frame[2 - CAP_FIRST];
    assign b4  = frame[4 - CAP_FIRST];
    assign b5  = frame[5 - CAP_FIRST];
    assign b6  = frame[6 - CAP_FIRST];
    assign b7  = frame[7 - CAP_FIRST];
    assign b8  = frame[8 - CAP_FIRST];
    assign b9  = frame[9 - CAP_FIRST];
    assign b10 = frame[10 - CAP_FIRST];
    assign b11 = frame[11 - CAP_FIRST];
    assign b12 = frame[12 - CAP_FIRST];

    assign addr = {b5, b6};
    assign s14  = b8[6:0];
    assign c28  = {b8[3:0], b8[4]};

    // Classify and update the records the frame carries.
    always_comb begin
        kind     = KIND_NONE;
        kept_new = kept_cur;
        if (b2 == HDR_LAN) begin
            unique case (b4)
                XH_STATUS: begin
                    unique case (b5)
                        ST_OFF:     kind = KIND_POWER_OFF;
                        ST_ON:      kind = KIND_POWER_ON;
                        ST_PROG:    kind = KIND_PROG;
                        ST_CV_NACK: kind = KIND_CV_NACK;
                        default:    kind = KIND_UNKNOWN;
                    endcase
                end
                XH_POWER: begin
                    unique case (b6)
                        PWR_ON:   kind = KIND_POWER_ON;
                        PWR_PROG: kind = KIND_PROG;
                        default:  kind = KIND_POWER_OFF;
                    endcase
                end
                XH_UNKNOWN_A, XH_UNKNOWN_B: kind = KIND_UNKNOWN;
                XH_CV: begin
                    kind               = KIND_CV_RESULT;
                    kept_new.cv_number = {b6, b7} + 16'd1;
                    kept_new.cv_value  = b8;
                end
                XH_LOCO: begin
                    kind = KIND_LOCO_INFO;
                    // Long addresses carry the two top bits as a prefix.
                    if (addr[15:14] == 2'b11) begin
                        kept_new.loco_address = {2'b00, addr[13:0]};
                    end else begin
                        kept_new.loco_address = addr;
                    end
                    unique case (b7[2:0])
                        STEP_CODE_14: begin
                            kept_new.speed_mode = MODE_14;
                            kept_new.loco_speed = (s14 != 7'd0) ? s14 - 7'd1 : 7'd0;
                        end
                        STEP_CODE_28: begin
                            // Stop and emergency stop codes both read as zero.
                            kept_new.speed_mode = MODE_28;
                            kept_new.loco_speed =
                                (c28 >= 5'd4) ? {2'b00, c28 - 5'd3} : 7'd0;
                        end
                        STEP_CODE_128: begin
                            kept_new.speed_mode = MODE_128;
                            kept_new.loco_speed = b8[6:0];
                        end
                        default: kept_new.speed_mode = MODE_UNKNOWN;
                    endcase
                    kept_new.occupied      = b7[3];
                    kept_new.forward       = b8[7];
                    kept_new.light_on      = b9[4];
                    kept_new.function_bits = {b12, b11, b10, b9[3:0]};
                end
                default: kind = KIND_NONE;
            endcase
        end
    end

endmodule

// ===== design/lan_response_frame_decoder_core.sv =====
// Top level of the LAN response frame decoder: result register and handshake.
// Depends on lrfd_pkg, lrfd_capture, lrfd_decode and the defines header.
//
// Usage:
//   The slave channel takes one datagram byte per transfer in s_tdata, with
//   s_tlast high on the final byte. Bytes 2 to 12 are captured; only the byte
//   marked last produces a result on the master channel, one per datagram.
//   A result carries the message kind in m_tuser and the kept loco and CV
//   records in m_tdata.
//   Pipeline: two register stages. m_tvalid rises once the last byte's
//   transfer has passed the frame register, then the result register.
//   Throughput: one byte per cycle, also across datagram bounds, while
//   the result register keeps up; a receiver stall can block the input.
//   When the receiver stalls, the result register holds and one finished
//   frame may wait in the frame register; while it waits, s_tready stays
//   low for every byte until the result register frees.
//   Reset (aresetn low, synchronous) clears the byte counter, the capture
//   window, the kept records and both valid flags.
`include "lan_response_frame_decoder_core_defines.svh"

module lan_response_frame_decoder_core import lrfd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] loco_address, [17:16] speed_mode, [24:18] loco_speed,
    // [25] occupied, [26] forward, [27] light_on, [55:28] function_bits,
    // [71:56] cv_number, [79:72] cv_value
    output logic [79:0] m_tdata,
    output logic [2:0]  m_tuser    // [2:0] message_kind
);

    logic   advance_ok;
    logic   frame_valid;
    frame_t frame;
    kind_t  kind_dec;
    kept_t  kept_dec;
    logic   out_load;

    kind_t  kind_reg;
    kept_t  kept_reg, kept_next;
    logic   m_tvalid_reg, m_tvalid_next;

    lrfd_capture u_capture (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .advance_ok  (advance_ok),
        .frame_valid (frame_valid),
        .frame       (frame)
    );

    lrfd_decode u_decode (
        .frame    (frame),
        .kept_cur (kept_reg),
        .kind     (kind_dec),
        .kept_new (kept_dec)
    );

    // The result register frees when empty or when its transfer completes.
    assign advance_ok = !m_tvalid_reg || m_tready;
    assign out_load   = frame_valid && advance_ok;

    always_comb begin
        kept_next     = out_load ? kept_dec : kept_reg;
        m_tvalid_next = out_load || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kept_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            kept_reg     <= kept_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            kind_reg <= kind_dec;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = kept_reg;
    assign m_tuser  = kind_reg;

    // A pending frame with a stalled result register blocks the input.
    `LRFD_ASSERT_NOW(a_block_when_full, aclk, aresetn, frame_valid && m_tvalid && !m_tready, !s_tready)
    // The byte marked last always yields a pending frame.
    `LRFD_ASSERT_NEXT(a_last_makes_frame, aclk, aresetn, s_tvalid && s_tready && s_tlast, frame_valid)
    // Kept records change only when a new result is loaded.
    `LRFD_ASSERT_NEXT(a_kept_hold, aclk, aresetn, !out_load, $stable(kept_reg))
    // A loaded frame always appears as a valid result.
    `LRFD_ASSERT_NEXT(a_load_shows, aclk, aresetn, out_load, m_tvalid)

endmodule

// ===== bench/lrfd_frame_checker.sv =====
// Checker for the LAN response frame decoder: watches the byte and result channels.
// Predicts each result from the accepted bytes and compares it field by field.
// Depends on lrfd_pkg for the header, kind and mode codes and the kept record layout.
module lrfd_frame_checker import lrfd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] loco_address, [17:16] speed_mode, [24:18] loco_speed,
    // [25] occupied, [26] forward, [27] light_on, [55:28] function_bits,
    // [71:56] cv_number, [79:72] cv_value
    input  logic [79:0] m_tdata,
    input  logic [2:0]  m_tuser,   // [2:0] message_kind
    output int unsigned error_count,
    output int unsigned results_pending
);

    localparam logic [15:0] LONG_PREFIX   = 16'hC000;
    localparam logic [15:0] SHORT_ADDR_MAX = 16'd127;

    typedef struct packed {
        kept_t rec;
        kind_t kind;
    } frame_result_t;

    logic [3:0]    byte_pos;
    logic [7:0]    window [CAP_COUNT];
    kept_t         kept;
    frame_result_t results_due [$];

    // Bytes outside the capture window, or never received, read as zero.
    function automatic logic [7:0] frame_byte(input int unsigned n);
        if (n < CAP_FIRST || n > CAP_LAST) return 8'h00;
        return window[n - CAP_FIRST];
    endfunction

    // Classifies the captured frame and updates the kept loco and CV records.
    function automatic kind_t decode_frame();
        logic [7:0]  b5;
        logic [7:0]  b6;
        logic [7:0]  b7;
        logic [7:0]  b8;
        logic [7:0]  b9;
        logic [15:0] addr;
        logic [4:0]  code28;
        logic [6:0]  steps;
        kind_t       kind;
        b5 = frame_byte(5);
        b6 = frame_byte(6);
        b7 = frame_byte(7);
        b8 = frame_byte(8);
        b9 = frame_byte(9);
        kind = KIND_NONE;
        if (frame_byte(2) == HDR_LAN) begin
            case (frame_byte(4))
                XH_STATUS: begin
                    case (b5)
                        ST_OFF:     kind = KIND_POWER_OFF;
                        ST_ON:      kind = KIND_POWER_ON;
                        ST_PROG:    kind = KIND_PROG;
                        ST_CV_NACK: kind = KIND_CV_NACK;
                        default:    kind = KIND_UNKNOWN;
                    endcase
                end
                XH_POWER: begin
                    case (b6)
                        PWR_ON:   kind = KIND_POWER_ON;
                        PWR_PROG: kind = KIND_PROG;
                        default:  kind = KIND_POWER_OFF;
                    endcase
                end
                XH_UNKNOWN_A, XH_UNKNOWN_B: kind = KIND_UNKNOWN;
                XH_CV: begin
                    kept.cv_number = {b6, b7} + 16'd1;
                    kept.cv_value  = b8;
                    kind = KIND_CV_RESULT;
                end
                XH_LOCO: begin
                    // Long addresses carry the two top bits set; strip them.
                    addr = {b5, b6};
                    if (addr > SHORT_ADDR_MAX && (addr & LONG_PREFIX) == LONG_PREFIX)
                        addr = addr - LONG_PREFIX;
                    kept.loco_address = addr;
                    case (b7[2:0])
                        STEP_CODE_14: begin
                            steps = b8[6:0];
                            if (steps != 7'd0) steps = steps - 7'd1;
                            kept.speed_mode = MODE_14;
                            kept.loco_speed = steps;
                        end
                        STEP_CODE_28: begin
                            // Bit 4 is the half step; stop and emergency stop read zero.
                            code28 = {b8[3:0], b8[4]};
                            kept.speed_mode = MODE_28;
                            kept.loco_speed = (code28 >= 5'd4) ? {2'b00, code28 - 5'd3} : 7'd0;
                        end
                        STEP_CODE_128: begin
                            kept.speed_mode = MODE_128;
                            kept.loco_speed = b8[6:0];
                        end
                        default: kept.speed_mode = MODE_UNKNOWN;
                    endcase
                    kept.occupied      = b7[3];
                    kept.forward       = b8[7];
                    kept.light_on      = b9[4];
                    kept.function_bits = {frame_byte(12), frame_byte(11), frame_byte(10),
                                          b9[3:0]};
                    kind = KIND_LOCO_INFO;
                end
                default: kind = KIND_NONE;
            endcase
        end
        return kind;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Track both channels on every rising edge out of reset.
    always @(posedge aclk) begin
        frame_result_t want;
        if (!aresetn) begin
            byte_pos = '0;
            foreach (window[i]) window[i] = '0;
            kept = '0;
            results_due.delete();
        end else begin
            // Result transfer: compare with the oldest prediction.
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result transfer with no result expected, expected none, actual %h %h",
                             $time, m_tuser, m_tdata);
                    error_count++;
                end else begin
                    want = results_due.pop_front();
                    check_field("message_kind",  32'(want.kind),              32'(m_tuser));
                    check_field("loco_address",  32'(want.rec.loco_address),  32'(m_tdata[15:0]));
                    check_field("speed_mode",    32'(want.rec.speed_mode),    32'(m_tdata[17:16]));
                    check_field("loco_speed",    32'(want.rec.loco_speed),    32'(m_tdata[24:18]));
                    check_field("occupied",      32'(want.rec.occupied),      32'(m_tdata[25]));
                    check_field("forward",       32'(want.rec.forward),       32'(m_tdata[26]));
                    check_field("light_on",      32'(want.rec.light_on),      32'(m_tdata[27]));
                    check_field("function_bits", 32'(want.rec.function_bits), 32'(m_tdata[55:28]));
                    check_field("cv_number",     32'(want.rec.cv_number),     32'(m_tdata[71:56]));
                    check_field("cv_value",      32'(want.rec.cv_value),      32'(m_tdata[79:72]));
                end
            end
            // Byte transfer: capture it and, on the last byte, predict the result.
            if (s_tvalid && s_tready) begin
                if (byte_pos >= CAP_FIRST && byte_pos <= CAP_LAST)
                    window[byte_pos - CAP_FIRST] = s_tdata;
                if (s_tlast) begin
                    want.kind = decode_frame();
                    want.rec  = kept;
                    results_due.push_back(want);
                    foreach (window[i]) window[i] = '0;
                    byte_pos = '0;
                end else if (byte_pos != POS_MAX) begin
                    byte_pos++;
                end
            end
        end
        results_pending = unsigned'(results_due.size());
    end

endmodule

// ===== bench/tb_top.sv =====
// Top of the LAN response frame decoder testbench: clock, reset, datagram stimulus, verdict.
// Depends on lrfd_pkg, lan_response_frame_decoder_core and lrfd_frame_checker.
module tb_top import lrfd_pkg::*;;

    localparam int unsigned RANDOM_BYTES   = 1800;
    localparam int unsigned IDLE_PERCENT   = 37;
    localparam int unsigned QUIET_FIRST    = 600;
    localparam int unsigned QUIET_LAST     = 900;
    localparam int unsigned DRAIN_CYCLES   = 10;
    localparam int unsigned FRAME_BYTES_MAX = 20;

    typedef enum int unsigned {
        SHAPE_LOCO,
        SHAPE_CV,
        SHAPE_STATUS,
        SHAPE_POWER,
        SHAPE_OTHER_X,
        SHAPE_NOISE
    } frame_shape_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [79:0] m_tdata;
    logic [2:0]  m_tuser;

    int unsigned error_count;
    int unsigned results_pending;
    bit          no_idle = 1'b0;
    int unsigned bytes_sent = 0;
    logic [7:0]  frame_q [$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    lan_response_frame_decoder_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lrfd_frame_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .error_count     (error_count),
        .results_pending (results_pending)
    );

    // Result receiver stalls at random, except during the quiet stretch.
    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Sends the queued datagram, one transfer per byte, last byte marked.
    task automatic send_frame();
        foreach (frame_q[i]) begin
            if (!no_idle) begin
                while ($urandom_range(99) < IDLE_PERCENT) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                end
            end
            s_tvalid <= 1'b1;
            s_tdata  <= frame_q[i];
            s_tlast  <= (i == frame_q.size() - 1);
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            bytes_sent++;
        end
        frame_q.delete();
    endtask

    // Builds a datagram of the given shape with random content.
    task automatic make_frame(input frame_shape_t shape);
        logic [7:0]  b [FRAME_BYTES_MAX];
        int unsigned len;
        foreach (b[i]) b[i] = 8'($urandom);
        b[2] = HDR_LAN;
        len = 13;
        case (shape)
            SHAPE_LOCO: begin
                b[4] = XH_LOCO;
                case ($urandom_range(2))
                    0: b[5][7:6] = 2'b11;
                    1: b[5] = 8'h00;
                    default: ;
                endcase
                case ($urandom_range(3))
                    0: b[7][2:0] = STEP_CODE_14;
                    1: b[7][2:0] = STEP_CODE_28;
                    2: b[7][2:0] = STEP_CODE_128;
                    default: ;
                endcase
            end
            SHAPE_CV: begin
                len  = 9;
                b[4] = XH_CV;
            end
            SHAPE_STATUS: begin
                len  = 6;
                b[4] = XH_STATUS;
                case ($urandom_range(4))
                    0: b[5] = ST_OFF;
                    1: b[5] = ST_ON;
                    2: b[5] = ST_PROG;
                    3: b[5] = ST_CV_NACK;
                    default: ;
                endcase
            end
            SHAPE_POWER: begin
                len = 7;
                b[4] = XH_POWER;
                case ($urandom_range(2))
                    0: b[6] = PWR_ON;
                    1: b[6] = PWR_PROG;
                    default: ;
                endcase
            end
            SHAPE_OTHER_X: begin
                len = $urandom_range(5, 13);
                case ($urandom_range(2))
                    0: b[4] = XH_UNKNOWN_A;
                    1: b[4] = XH_UNKNOWN_B;
                    default: ;
                endcase
            end
            default: begin
                len = $urandom_range(1, FRAME_BYTES_MAX);
                if ($urandom_range(1) == 0) b[2] = 8'($urandom);
            end
        endcase
        // One frame in ten is cut short or runs long.
        if ($urandom_range(9) == 0) len = $urandom_range(1, FRAME_BYTES_MAX);
        for (int i = 0; i < len; i++) frame_q.push_back(b[i]);
    endtask

    // Stimulus: reset, directed frames, random frames, drain and verdict.
    initial begin
        int unsigned random_start;
        int unsigned pick;
        frame_shape_t shape;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A lone byte marked last: short frame, reports the reset records.
        frame_q = '{8'hFF};
        send_frame();
        // Loco info at the field extremes, long address, with a trailing extra byte.
        frame_q = '{8'h0E, 8'h00, HDR_LAN, 8'h00, XH_LOCO, 8'hFF, 8'hFF, 8'h08,
                    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        send_frame();
        // Status frame reporting a CV negative acknowledge.
        frame_q = '{8'h07, 8'h00, HDR_LAN, 8'h00, XH_STATUS, ST_CV_NACK};
        send_frame();
        // Track power frame in programming mode.
        frame_q = '{8'h07, 8'h00, HDR_LAN, 8'h00, XH_POWER, 8'h00, PWR_PROG};
        send_frame();

        // Random part: mostly well-formed frames, the rest broken or foreign.
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            no_idle = (bytes_sent - random_start >= QUIET_FIRST) &&
                      (bytes_sent - random_start < QUIET_LAST);
            pick = $urandom_range(99);
            if (pick < 35)      shape = SHAPE_LOCO;
            else if (pick < 50) shape = SHAPE_CV;
            else if (pick < 65) shape = SHAPE_STATUS;
            else if (pick < 80) shape = SHAPE_POWER;
            else if (pick < 88) shape = SHAPE_OTHER_X;
            else                shape = SHAPE_NOISE;
            make_frame(shape);
            send_frame();
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // Let the last predictions arrive, then allow for the pipeline.
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (results_pending != 0)
            $display("%0t: %0d expected results never arrived", $time, results_pending);
        if (error_count == 0 && results_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/lrfd_pkg.sv
design/lrfd_capture.sv
design/lrfd_decode.sv
design/lan_response_frame_decoder_core.sv
bench/lrfd_frame_checker.sv
bench/tb_top.sv
